// ----- src/hcv_pkg.sv -----
package hcv_pkg;

  // Field widths
  localparam int CH_W       = 8;
  localparam int HUE_W      = 10;
  localparam int CLS_W      = 3;
  localparam int BAND_W     = 9;
  localparam int CFG_IDX_W  = 3;

  // Divider geometry: dividend is 60 * |diff|, quotient never exceeds 60
  localparam int DIVIDEND_W = 14;
  localparam int Q_W        = 6;
  localparam int DSH_W      = CH_W + Q_W - 1;
  localparam int STEP_W     = $clog2(Q_W);

  // Vote counters
  localparam int NUM_CLASSES    = 5;
  localparam int VOTE_COUNT_MAX = 15;
  localparam int VOTE_W         = $clog2(VOTE_COUNT_MAX + 1);

  // Class codes
  localparam logic [CLS_W-1:0] CLS_RED        = 3'd0;
  localparam logic [CLS_W-1:0] CLS_GREEN      = 3'd1;
  localparam logic [CLS_W-1:0] CLS_BLUE       = 3'd2;
  localparam logic [CLS_W-1:0] CLS_YELLOW     = 3'd3;
  localparam logic [CLS_W-1:0] CLS_BACKGROUND = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RED_BELOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FROM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YELLOW_FROM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FROM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_TO    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FROM   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_TO     = 3'd6;

  // Sextant offsets, chosen by the minimum channel
  localparam logic [BAND_W-1:0] OFS_BLUE_MIN  = 9'd60;
  localparam logic [BAND_W-1:0] OFS_RED_MIN   = 9'd180;
  localparam logic [BAND_W-1:0] OFS_GREEN_MIN = 9'd300;

  // Band register reset values
  localparam logic [BAND_W-1:0] RST_RED_BELOW   = 9'd10;
  localparam logic [BAND_W-1:0] RST_RED_FROM    = 9'd340;
  localparam logic [BAND_W-1:0] RST_YELLOW_FROM = 9'd40;
  localparam logic [BAND_W-1:0] RST_GREEN_FROM  = 9'd80;
  localparam logic [BAND_W-1:0] RST_GREEN_TO    = 9'd140;
  localparam logic [BAND_W-1:0] RST_BLUE_FROM   = 9'd220;
  localparam logic [BAND_W-1:0] RST_BLUE_TO     = 9'd280;

  typedef struct packed {
    logic [BAND_W-1:0] red_below;
    logic [BAND_W-1:0] red_from;
    logic [BAND_W-1:0] yellow_from;
    logic [BAND_W-1:0] green_from;
    logic [BAND_W-1:0] green_to;
    logic [BAND_W-1:0] blue_from;
    logic [BAND_W-1:0] blue_to;
  } hcv_bands_t;

  typedef struct packed {
    logic count;   // classify the hue and cast its vote
    logic tally;   // result taken from the counters this cycle
    logic close;   // window ends with this item: clear after the tally
  } hcv_vote_ctrl_t;

endpackage

// ----- src/hcv_in_if.sv -----
interface hcv_in_if;
  import hcv_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            window_end;

  modport source (output valid, red, green, blue, window_end, input ready);
  modport sink   (input valid, red, green, blue, window_end, output ready);
endinterface

// ----- src/hcv_out_if.sv -----
interface hcv_out_if;
  import hcv_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [HUE_W-1:0] hue;
  logic [CLS_W-1:0]        sample_class;
  logic                    vote_valid;
  logic [CLS_W-1:0]        vote_class;

  modport source (output valid, hue, sample_class, vote_valid, vote_class, input ready);
  modport sink   (input valid, hue, sample_class, vote_valid, vote_class, output ready);
endinterface

// ----- src/hcv_div.sv -----
module hcv_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [hcv_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [hcv_pkg::CH_W-1:0]        divisor,
  output logic                            done,
  output logic [hcv_pkg::Q_W-1:0]         quotient
);
  import hcv_pkg::*;

  logic [DIVIDEND_W-1:0] rem;
  logic [DSH_W-1:0]      dsh;
  logic [Q_W-1:0]        quo;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  fits;
  logic [DIVIDEND_W-1:0] dsh_ext;

  assign dsh_ext  = DIVIDEND_W'(dsh);
  assign fits     = dsh_ext <= rem;
  assign quotient = quo;

  // Restoring division, one quotient bit a cycle, divisor shifted right each step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (load) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= STEP_W'(Q_W - 1);
    end else begin
      done <= busy && (step == '0);
      if (busy) begin
        step <= step - 1'b1;
        if (step == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Hold the datapath between steps
  always_ff @(posedge clk) begin
    if (load) begin
      rem <= dividend;
      dsh <= {divisor, (Q_W-1)'(0)};
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh_ext;
      end
      dsh <= dsh >> 1;
      quo <= {quo[Q_W-2:0], fits};
    end
  end

endmodule

// ----- src/hcv_vote.sv -----
module hcv_vote (
  input  logic                           clk,
  input  logic                           rst,
  input  hcv_pkg::hcv_vote_ctrl_t        ctrl,
  input  hcv_pkg::hcv_bands_t            bands,
  input  logic signed [hcv_pkg::HUE_W-1:0] hue,
  output logic [hcv_pkg::CLS_W-1:0]      sample_class,
  output logic [hcv_pkg::CLS_W-1:0]      best
);
  import hcv_pkg::*;

  logic [VOTE_W-1:0]       votes [NUM_CLASSES];
  logic signed [HUE_W:0]   hs;
  logic                    lt_red_below, lt_red_from, lt_yellow_from, lt_green_from;
  logic                    lt_green_to, lt_blue_from, lt_blue_to;
  logic [CLS_W-1:0]        cls;
  logic [VOTE_W-1:0]       best_votes;

  // Compare the signed hue against the unsigned bounds, one bit wider
  assign hs             = {hue[HUE_W-1], hue};
  assign lt_red_below   = hs < $signed({2'b00, bands.red_below});
  assign lt_red_from    = hs < $signed({2'b00, bands.red_from});
  assign lt_yellow_from = hs < $signed({2'b00, bands.yellow_from});
  assign lt_green_from  = hs < $signed({2'b00, bands.green_from});
  assign lt_green_to    = hs < $signed({2'b00, bands.green_to});
  assign lt_blue_from   = hs < $signed({2'b00, bands.blue_from});
  assign lt_blue_to     = hs < $signed({2'b00, bands.blue_to});

  // First matching band wins: red, yellow, green, blue, else background
  always_comb begin
    if (lt_red_below || !lt_red_from) begin
      cls = CLS_RED;
    end else if (!lt_yellow_from && lt_green_from) begin
      cls = CLS_YELLOW;
    end else if (!lt_green_from && lt_green_to) begin
      cls = CLS_GREEN;
    end else if (!lt_blue_from && lt_blue_to) begin
      cls = CLS_BLUE;
    end else begin
      cls = CLS_BACKGROUND;
    end
  end

  // Hold the class of the item in hand
  always_ff @(posedge clk) begin
    if (ctrl.count) begin
      sample_class <= cls;
    end
  end

  // Saturating counters, cleared when a window closes
  always_ff @(posedge clk) begin
    if (rst || (ctrl.tally && ctrl.close)) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        votes[i] <= '0;
      end
    end else if (ctrl.count) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (CLS_W'(i) == cls && votes[i] < VOTE_W'(VOTE_COUNT_MAX)) begin
          votes[i] <= votes[i] + 1'b1;
        end
      end
    end
  end

  // Majority: strictly greater replaces, so ties keep the lowest code
  always_comb begin
    best       = CLS_RED;
    best_votes = votes[0];
    for (int i = 1; i < NUM_CLASSES; i++) begin
      if (votes[i] > best_votes) begin
        best       = CLS_W'(i);
        best_votes = votes[i];
      end
    end
  end

endmodule

// ----- src/hue_color_classifier_vote.sv -----
// Channel  | Dir | Payload                                       | Accepted when
// ---------+-----+-----------------------------------------------+----------------------
// sample   | in  | red, green, blue, window_end                  | valid && ready
// result   | out | hue, sample_class, vote_valid, vote_class     | valid && ready
// cfg      | in  | cfg_index, cfg_data (band registers 0..6)     | cfg_we
//
// One item at a time: after an item is accepted, the six-step serial divider runs and
// raises its done flag, then come the hue, vote and tally states, and the idle state
// that takes the next item.
// A finished result sits in the output register; a new item is taken while it waits.
// If the output register is still full at tally time, the item waits in tally.
// Synchronous reset clears control state and the vote counters, and loads band defaults.
module hue_color_classifier_vote (
  input  logic                            clk,
  input  logic                            rst,
  hcv_in_if.sink                          sample,
  hcv_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [hcv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hcv_pkg::BAND_W-1:0]      cfg_data
);
  import hcv_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_HUE   = 5'b00100,
    ST_COUNT = 5'b01000,
    ST_TALLY = 5'b10000
  } hcv_state_t;

  hcv_state_t state, state_next;

  hcv_bands_t       bands;
  hcv_vote_ctrl_t   vctrl;

  logic                    accept;
  logic                    grey, b_min, r_min;
  logic [CH_W-1:0]         pos, neg, mn, mx, span, mag;
  logic                    diff_neg;
  logic [BAND_W-1:0]       offset;
  logic [DIVIDEND_W-1:0]   dividend;
  logic                    div_done;
  logic [Q_W-1:0]          quotient;

  logic                    grey_q, neg_q, last_q;
  logic [BAND_W-1:0]       offset_q;
  logic signed [HUE_W-1:0] hue_q;
  logic [CLS_W-1:0]        sample_class, best;
  logic                    out_free;

  logic                    out_valid;
  logic signed [HUE_W-1:0] out_hue;
  logic [CLS_W-1:0]        out_class, out_vote_class;
  logic                    out_vote_valid;

  assign accept   = sample.valid && sample.ready;
  assign out_free = !out_valid || result.ready;

  // Band registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bands.red_below   <= RST_RED_BELOW;
      bands.red_from    <= RST_RED_FROM;
      bands.yellow_from <= RST_YELLOW_FROM;
      bands.green_from  <= RST_GREEN_FROM;
      bands.green_to    <= RST_GREEN_TO;
      bands.blue_from   <= RST_BLUE_FROM;
      bands.blue_to     <= RST_BLUE_TO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RED_BELOW:   bands.red_below   <= cfg_data;
        REG_RED_FROM:    bands.red_from    <= cfg_data;
        REG_YELLOW_FROM: bands.yellow_from <= cfg_data;
        REG_GREEN_FROM:  bands.green_from  <= cfg_data;
        REG_GREEN_TO:    bands.green_to    <= cfg_data;
        REG_BLUE_FROM:   bands.blue_from   <= cfg_data;
        REG_BLUE_TO:     bands.blue_to     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pick the sextant from the minimum channel and form 60 * |diff|
  always_comb begin
    grey  = (sample.red == sample.green) && (sample.green == sample.blue);
    b_min = (sample.blue <= sample.green) && (sample.blue <= sample.red);
    r_min = (sample.red <= sample.green) && (sample.red <= sample.blue);
    if (b_min) begin
      pos = sample.green; neg = sample.red;   mn = sample.blue;  offset = OFS_BLUE_MIN;
    end else if (r_min) begin
      pos = sample.blue;  neg = sample.green; mn = sample.red;   offset = OFS_RED_MIN;
    end else begin
      pos = sample.red;   neg = sample.blue;  mn = sample.green; offset = OFS_GREEN_MIN;
    end
    diff_neg = pos < neg;
    mx       = diff_neg ? neg : pos;
    mag      = diff_neg ? (neg - pos) : (pos - neg);
    span     = mx - mn;
    dividend = {mag, 6'b000000} - {4'b0000, mag, 2'b00};
  end

  // Hold what the hue needs besides the quotient
  always_ff @(posedge clk) begin
    if (accept) begin
      grey_q   <= grey;
      neg_q    <= diff_neg;
      offset_q <= offset;
      last_q   <= sample.window_end;
    end
  end

  hcv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  // Apply sign and sextant offset; grey gives all ones
  always_ff @(posedge clk) begin
    if (state == ST_HUE) begin
      if (grey_q) begin
        hue_q <= '1;
      end else if (neg_q) begin
        hue_q <= $signed({1'b0, offset_q} - HUE_W'(quotient));
      end else begin
        hue_q <= $signed({1'b0, offset_q} + HUE_W'(quotient));
      end
    end
  end

  assign vctrl.count = (state == ST_COUNT);
  assign vctrl.tally = (state == ST_TALLY) && out_free;
  assign vctrl.close = last_q;

  hcv_vote u_vote (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (vctrl),
    .bands        (bands),
    .hue          (hue_q),
    .sample_class (sample_class),
    .best         (best)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_HUE;
      ST_HUE:   state_next = ST_COUNT;
      ST_COUNT: state_next = ST_TALLY;
      ST_TALLY: if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register: load on tally, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (vctrl.tally) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vctrl.tally) begin
      out_hue        <= hue_q;
      out_class      <= sample_class;
      out_vote_valid <= last_q;
      out_vote_class <= last_q ? best : CLS_RED;
    end
  end

  assign sample.ready        = (state == ST_IDLE);
  assign result.valid        = out_valid;
  assign result.hue          = out_hue;
  assign result.sample_class = out_class;
  assign result.vote_valid   = out_vote_valid;
  assign result.vote_class   = out_vote_class;

  // An accepted item always starts the divider
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DIV)
    else $error("accepted item did not enter divide");

  // The divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide");

  // Grey always lands in the red band
  a_grey_red: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.hue == '1) |-> result.sample_class == CLS_RED)
    else $error("grey sample not classed red");

  // No window close, no vote class
  a_vote_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.vote_valid) |-> result.vote_class == CLS_RED)
    else $error("vote class set without window end");

endmodule

// ----- tb/hcv_verdict_check.sv -----
module hcv_verdict_check (
  input  logic                          clk,
  input  logic                          rst,
  hcv_in_if                             sample,
  hcv_out_if                            result,
  input  logic                          cfg_we,
  input  logic [hcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hcv_pkg::BAND_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            awaited
);
  import hcv_pkg::*;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    logic [CLS_W-1:0]        sample_class;
    logic                    vote_valid;
    logic [CLS_W-1:0]        vote_class;
  } verdict_t;

  hcv_bands_t        bands;
  logic [VOTE_W-1:0] votes [NUM_CLASSES];
  verdict_t          verdict_q [$];

  // Integer hue in degrees, truncating division, -1 for grey
  function automatic int hue_degrees(int r, int g, int b);
    int hi;
    int num;
    if (r == g && g == b)
      return -1;
    if (b <= g && b <= r) begin
      hi  = (g > r) ? g : r;
      num = 60 * (g - r);
      return num / (hi - b) + int'(OFS_BLUE_MIN);
    end
    if (r <= g && r <= b) begin
      hi  = (b > g) ? b : g;
      num = 60 * (b - g);
      return num / (hi - r) + int'(OFS_RED_MIN);
    end
    // green is the smallest channel
    hi  = (r > b) ? r : b;
    num = 60 * (r - b);
    return num / (hi - g) + int'(OFS_GREEN_MIN);
  endfunction

  // First matching band wins: red, yellow, green, blue, else background
  function automatic logic [CLS_W-1:0] band_class(int h);
    if (h < int'(bands.red_below) || h >= int'(bands.red_from))
      return CLS_RED;
    if (h >= int'(bands.yellow_from) && h < int'(bands.green_from))
      return CLS_YELLOW;
    if (h >= int'(bands.green_from) && h < int'(bands.green_to))
      return CLS_GREEN;
    if (h >= int'(bands.blue_from) && h < int'(bands.blue_to))
      return CLS_BLUE;
    return CLS_BACKGROUND;
  endfunction

  // Classify one sample, cast its vote and close the window if flagged
  function automatic verdict_t tally_sample(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                            logic [CH_W-1:0] b, logic last);
    verdict_t v;
    int       h;
    int       best;
    h = hue_degrees(int'(r), int'(g), int'(b));
    v.hue = HUE_W'(h);
    v.sample_class = band_class(h);
    v.vote_valid = last;
    v.vote_class = CLS_RED;
    if (votes[v.sample_class] < VOTE_COUNT_MAX)
      votes[v.sample_class] = votes[v.sample_class] + 1'b1;
    if (last) begin
      best = 0;
      for (int i = 1; i < NUM_CLASSES; i++)
        if (votes[i] > votes[best])
          best = i;
      v.vote_class = CLS_W'(best);
      for (int i = 0; i < NUM_CLASSES; i++)
        votes[i] = '0;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t seen;
    verdict_t want;
    if (rst) begin
      bands = '{red_below: RST_RED_BELOW, red_from: RST_RED_FROM,
                yellow_from: RST_YELLOW_FROM, green_from: RST_GREEN_FROM,
                green_to: RST_GREEN_TO, blue_from: RST_BLUE_FROM, blue_to: RST_BLUE_TO};
      for (int i = 0; i < NUM_CLASSES; i++)
        votes[i] = '0;
      verdict_q.delete();
      mismatches = 0;
    end else begin
      // Compare a delivered item against the oldest prediction
      if (result.valid && result.ready) begin
        seen = '{result.hue, result.sample_class, result.vote_valid, result.vote_class};
        if (verdict_q.size() == 0) begin
          $error("unexpected result item: hue %0d class %0d", seen.hue, seen.sample_class);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (seen.hue !== want.hue) begin
            $error("hue: expected %0d, got %0d", want.hue, seen.hue);
            mismatches++;
          end
          if (seen.sample_class !== want.sample_class) begin
            $error("sample_class: expected %0d, got %0d", want.sample_class,
                   seen.sample_class);
            mismatches++;
          end
          if (seen.vote_valid !== want.vote_valid) begin
            $error("vote_valid: expected %0d, got %0d", want.vote_valid, seen.vote_valid);
            mismatches++;
          end
          if (seen.vote_class !== want.vote_class) begin
            $error("vote_class: expected %0d, got %0d", want.vote_class, seen.vote_class);
            mismatches++;
          end
        end
      end

      // Track band register writes; indexes past the last register are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_RED_BELOW:   bands.red_below   = cfg_data;
          REG_RED_FROM:    bands.red_from    = cfg_data;
          REG_YELLOW_FROM: bands.yellow_from = cfg_data;
          REG_GREEN_FROM:  bands.green_from  = cfg_data;
          REG_GREEN_TO:    bands.green_to    = cfg_data;
          REG_BLUE_FROM:   bands.blue_from   = cfg_data;
          REG_BLUE_TO:     bands.blue_to     = cfg_data;
          default: ;
        endcase
      end

      if (sample.valid && sample.ready)
        verdict_q.push_back(tally_sample(sample.red, sample.green, sample.blue,
                                         sample.window_end));
    end
    awaited = verdict_q.size();
  end

endmodule

// ----- tb/hue_color_classifier_vote_tb.sv -----
module hue_color_classifier_vote_tb;
  import hcv_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 130;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 40;

  // Index past the last band register: writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum {PACE_STEADY, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BAND_W-1:0]    cfg_data;

  int mismatches;
  int awaited;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  hcv_in_if  sample_ch ();
  hcv_out_if result_ch ();

  always #1 clk = ~clk;

  hue_color_classifier_vote dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hcv_verdict_check verdicts (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample_ch),
    .result     (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("hue_color_classifier_vote: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(input pace_t pace);
    send_idle_pct = (pace == PACE_SENDER_IDLE) ? 70 : (pace == PACE_BOTH) ? 33 : 0;
    stall_pct     = (pace == PACE_RECEIVER_STALL) ? 70 : (pace == PACE_BOTH) ? 33 : 0;
  endtask

  // Offer one item and hold it until it is taken
  task automatic send_sample(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid      <= 1'b1;
    sample_ch.red        <= r;
    sample_ch.green      <= g;
    sample_ch.blue       <= b;
    sample_ch.window_end <= last;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted item has come back
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BAND_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_bands(input hcv_bands_t bset, input logic [BAND_W-1:0] spare);
    write_reg(REG_RED_BELOW, bset.red_below);
    write_reg(REG_RED_FROM, bset.red_from);
    write_reg(REG_YELLOW_FROM, bset.yellow_from);
    write_reg(REG_GREEN_FROM, bset.green_from);
    write_reg(REG_GREEN_TO, bset.green_to);
    write_reg(REG_BLUE_FROM, bset.blue_from);
    write_reg(REG_BLUE_TO, bset.blue_to);
    write_reg(REG_SPARE, spare);
    cfg_we <= 1'b0;
  endtask

  function automatic hcv_bands_t random_bands(int hi);
    hcv_bands_t bset;
    bset.red_below   = BAND_W'($urandom_range(hi));
    bset.red_from    = BAND_W'($urandom_range(hi));
    bset.yellow_from = BAND_W'($urandom_range(hi));
    bset.green_from  = BAND_W'($urandom_range(hi));
    bset.green_to    = BAND_W'($urandom_range(hi));
    bset.blue_from   = BAND_W'($urandom_range(hi));
    bset.blue_to     = BAND_W'($urandom_range(hi));
    return bset;
  endfunction

  function automatic logic [CH_W-1:0] rim_channel();
    case ($urandom_range(2))
      0:       return '0;
      1:       return '1;
      default: return CH_W'($urandom_range(255));
    endcase
  endfunction

  // Mix of greys, saturated corners, near-greys and plain uniform colours
  function automatic rgb_t random_rgb();
    rgb_t s;
    int   base;
    int   v [3];
    base = $urandom_range(255);
    case ($urandom_range(5))
      0: s = '{CH_W'(base), CH_W'(base), CH_W'(base)};
      1: s = '{rim_channel(), rim_channel(), rim_channel()};
      2: begin
        for (int i = 0; i < 3; i++) begin
          v[i] = base + int'($urandom_range(4)) - 2;
          v[i] = (v[i] < 0) ? 0 : (v[i] > 255) ? 255 : v[i];
        end
        s = '{CH_W'(v[0]), CH_W'(v[1]), CH_W'(v[2])};
      end
      default: s = '{CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
    endcase
    return s;
  endfunction

  // Vote windows of random length; the last item of the phase closes its window
  task automatic run_windows(input int items, input bit squeeze);
    int   sent;
    int   span;
    rgb_t s;
    sent = 0;
    while (sent < items) begin
      span = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int k = 0; k < span && sent < items; k++) begin
        if (squeeze && sent == items / 3)
          holds_asked <= holds_asked + 1;
        s = random_rgb();
        send_sample(s.red, s.green, s.blue, (k == span - 1) || (sent == items - 1));
        sent++;
      end
    end
  endtask

  initial begin
    hcv_bands_t bset;
    pace_t      pace;
    bit         squeeze;

    sample_ch.valid      = 1'b0;
    sample_ch.red        = '0;
    sample_ch.green      = '0;
    sample_ch.blue       = '0;
    sample_ch.window_end = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: greys, primaries, sextant corners, rounding toward zero, vote ties
    send_sample(8'd0, 8'd0, 8'd0, 1'b0);
    send_sample(8'd255, 8'd255, 8'd255, 1'b0);
    send_sample(8'd128, 8'd128, 8'd128, 1'b1);
    send_sample(8'd255, 8'd0, 8'd0, 1'b0);
    send_sample(8'd0, 8'd255, 8'd0, 1'b1);
    send_sample(8'd0, 8'd0, 8'd255, 1'b0);
    send_sample(8'd255, 8'd255, 8'd0, 1'b0);
    send_sample(8'd0, 8'd255, 8'd255, 1'b0);
    send_sample(8'd255, 8'd0, 8'd255, 1'b0);
    send_sample(8'd255, 8'd1, 8'd0, 1'b0);
    send_sample(8'd255, 8'd0, 8'd1, 1'b0);
    send_sample(8'd0, 8'd1, 8'd255, 1'b0);
    send_sample(8'd1, 8'd0, 8'd0, 1'b0);
    send_sample(8'd0, 8'd1, 8'd0, 1'b0);
    send_sample(8'd0, 8'd0, 8'd1, 1'b0);
    send_sample(8'd10, 8'd5, 8'd10, 1'b1);
    send_sample(8'd200, 8'd100, 8'd0, 1'b0);
    send_sample(8'd100, 8'd200, 8'd0, 1'b0);
    send_sample(8'd0, 8'd100, 8'd200, 1'b0);
    send_sample(8'd0, 8'd200, 8'd100, 1'b0);
    send_sample(8'd255, 8'd254, 8'd253, 1'b1);
    drain_results();

    // Random phases, each with its own band setting and pacing
    for (int ph = 0; ph < PHASES; ph++) begin
      squeeze = (ph == 0) || (ph == 6);
      pace    = pace_t'(ph % 4);
      case (ph)
        1: bset = '{9'd0, 9'd360, 9'd0, 9'd60, 9'd180, 9'd180, 9'd360};
        2: bset = '{9'd0, 9'd511, 9'd511, 9'd0, 9'd511, 9'd0, 9'd511};
        3: bset = '{9'd360, 9'd360, 9'd360, 9'd360, 9'd360, 9'd360, 9'd360};
        4: bset = random_bands(360);
        5: bset = random_bands(511);
        6: bset = '{RST_RED_BELOW, RST_RED_FROM, RST_YELLOW_FROM, RST_GREEN_FROM,
                    RST_GREEN_TO, RST_BLUE_FROM, RST_BLUE_TO};
        default: bset = random_bands(360);
      endcase
      if (ph != 0)
        load_bands(bset, BAND_W'($urandom));
      set_pace(pace);
      run_windows(PHASE_ITEMS, squeeze);
      drain_results();
    end

    // Let any stray result show up before the verdict
    set_pace(PACE_STEADY);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("hue_color_classifier_vote: match");
    else
      $display("hue_color_classifier_vote: mismatch");
    $finish;
  end

endmodule

// ----- files.f -----
src/hcv_pkg.sv
src/hcv_in_if.sv
src/hcv_out_if.sv
src/hcv_div.sv
src/hcv_vote.sv
src/hue_color_classifier_vote.sv
tb/hcv_verdict_check.sv
tb/hue_color_classifier_vote_tb.sv
